### rtl/assert_macros.svh
// Assertion macros for the route table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/lpm_rt_pkg.sv
// Package: types, codes and helpers for the route table.
package lpm_rt_pkg;
  localparam int TableSize = 16;
  localparam int IntfCount = 16;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_DEL = 3'd1;
  localparam logic [2:0] OP_FWD = 3'd2;
  localparam logic [2:0] OP_LOCAL = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [3:0] ST_ADDED = 4'd0;
  localparam logic [3:0] ST_REPLACED = 4'd1;
  localparam logic [3:0] ST_IDENT = 4'd2;
  localparam logic [3:0] ST_FULL = 4'd3;
  localparam logic [3:0] ST_DELETED = 4'd4;
  localparam logic [3:0] ST_NOT_FOUND = 4'd5;
  localparam logic [3:0] ST_GATEWAY = 4'd6;
  localparam logic [3:0] ST_DIRECT = 4'd7;
  localparam logic [3:0] ST_NO_ROUTE = 4'd8;
  localparam logic [3:0] ST_TTL_EXP = 4'd9;
  localparam logic [3:0] ST_CLEARED = 4'd10;

  // One table entry as it moves along the chain.
  typedef struct packed {
    logic        valid;
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        direct;
    logic [31:0] gateway;
    logic [3:0]  intf;
  } entry_t;

  // Command that rides with the rotation, used by the chain's write slot.
  typedef struct packed {
    logic   write;
    entry_t data;
  } slot_cmd_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '1;
    if (len == 6'd0) begin
      len_mask = '0;
    end else begin
      len_mask = m << (6'd32 - len);
    end
  endfunction
endpackage

### rtl/lpm_rt_cell.sv
// One storage cell of the rotating entry chain.
module lpm_rt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic                clear,
  input  lpm_rt_pkg::entry_t  din,
  output lpm_rt_pkg::entry_t  dout
);
  lpm_rt_pkg::entry_t ent;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ent.valid <= 1'b0;
    end else if (shift) begin
      ent <= din;
    end
  end

  assign dout = ent;
endmodule

### rtl/lpm_rt_chain.sv
// Ring of entry cells; the head cell may be overwritten as it passes.
module lpm_rt_chain #(
  parameter int TABLE_SIZE = lpm_rt_pkg::TableSize
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic                  clear,
  input  lpm_rt_pkg::slot_cmd_t cmd,
  output lpm_rt_pkg::entry_t    head
);
  lpm_rt_pkg::entry_t link [TABLE_SIZE];
  lpm_rt_pkg::entry_t feed;

  // Replace the head entry as it wraps around to the tail.
  assign feed = cmd.write ? cmd.data : link[0];

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
    lpm_rt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .clear (clear),
      .din   ((g == TABLE_SIZE - 1) ? feed : link[(g + 1) % TABLE_SIZE]),
      .dout  (link[g])
    );
  end

  assign head = link[0];
endmodule

### rtl/lpm_route_table_unit.sv
// Top level: IPv4 longest-prefix-match route table on a rotating cell chain.
// A lookup makes one pass of the ring past a single comparator, then decides in S_DONE;
// add and delete take a second write pass before S_DONE; clear answers on the next cycle.
// Input waits until the result transfers, so a new request is not taken while one is busy.
// Synchronous reset clears all entry valid bits and the control state.
`include "assert_macros.svh"
module lpm_route_table_unit #(
  parameter int TABLE_SIZE = lpm_rt_pkg::TableSize,
  parameter int INTF_COUNT = lpm_rt_pkg::IntfCount
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] address,
  input  logic [5:0]  prefix_len,
  input  logic        direct_route,
  input  logic [31:0] gateway,
  input  logic [3:0]  out_intf,
  input  logic [7:0]  ttl_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [31:0] next_hop,
  output logic [3:0]  result_intf,
  output logic [7:0]  ttl_out,
  output logic [5:0]  matched_len
);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [CW-1:0] LAST = CW'(TABLE_SIZE - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] cnt;

  logic [2:0]  op;
  logic [31:0] addr;
  logic [5:0]  len;
  logic        dir;
  logic [31:0] gw;
  logic [3:0]  intf;
  logic [7:0]  ttl;

  // Scan results, indexed by distance from the head at scan start.
  logic          exact_hit;
  logic [CW-1:0] exact_pos;
  logic          free_hit;
  logic [CW-1:0] free_pos;
  logic          ident;
  logic          lpm_hit;
  lpm_rt_pkg::entry_t best;

  logic               shift;
  logic               clear;
  lpm_rt_pkg::slot_cmd_t cmd;
  lpm_rt_pkg::entry_t head;

  logic [5:0]  in_len;
  logic [31:0] in_gw;
  logic [3:0]  in_intf;
  logic [3:0]  intf_wrap [16];

  logic [3:0]  status_next;
  logic [31:0] next_hop_next;
  logic [3:0]  result_intf_next;
  logic [7:0]  ttl_out_next;
  logic [5:0]  matched_len_next;

  lpm_rt_chain #(.TABLE_SIZE(TABLE_SIZE)) u_chain (
    .clk   (clk),
    .rst   (rst),
    .shift (shift),
    .clear (clear),
    .cmd   (cmd),
    .head  (head)
  );

  // Interface wrap as a constant lookup.
  for (genvar g = 0; g < 16; g++) begin : g_wrap
    assign intf_wrap[g] = 4'(g % INTF_COUNT);
  end

  assign in_len  = (prefix_len > 6'd32) ? 6'd32 : prefix_len;
  assign in_gw   = direct_route ? 32'd0 : gateway;
  assign in_intf = direct_route ? 4'd0 : intf_wrap[out_intf];

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign shift = (state == S_SCAN) || (state == S_WRITE);
  assign clear = (state == S_IDLE) && in_valid && in_ready && (operation == lpm_rt_pkg::OP_CLEAR);

  logic head_exact;
  logic head_match;
  assign head_exact = head.valid && head.prefix == addr && head.len == len;
  assign head_match = head.valid &&
                      ((addr & lpm_rt_pkg::len_mask(head.len)) == head.prefix);

  // Write slot during the second pass: add or delete lands on its target.
  always_comb begin
    cmd = '0;
    if (state == S_WRITE) begin
      if (op == lpm_rt_pkg::OP_DEL) begin
        if (exact_hit && cnt == exact_pos) begin
          cmd.write = 1'b1;
          cmd.data = head;
          cmd.data.valid = 1'b0;
        end
      end else if (exact_hit) begin
        if (cnt == exact_pos && !ident) begin
          cmd.write = 1'b1;
          cmd.data = head;
          cmd.data.direct = dir;
          cmd.data.gateway = gw;
          cmd.data.intf = intf;
        end
      end else if (free_hit && cnt == free_pos) begin
        cmd.write = 1'b1;
        cmd.data.valid = 1'b1;
        cmd.data.prefix = addr;
        cmd.data.len = len;
        cmd.data.direct = dir;
        cmd.data.gateway = gw;
        cmd.data.intf = intf;
      end
    end
  end

  // Result of the finished scan.
  always_comb begin
    status_next = lpm_rt_pkg::ST_NO_ROUTE;
    next_hop_next = '0;
    result_intf_next = '0;
    ttl_out_next = '0;
    matched_len_next = '0;
    if (op == lpm_rt_pkg::OP_ADD) begin
      if (exact_hit) begin
        status_next = ident ? lpm_rt_pkg::ST_IDENT : lpm_rt_pkg::ST_REPLACED;
      end else begin
        status_next = free_hit ? lpm_rt_pkg::ST_ADDED : lpm_rt_pkg::ST_FULL;
      end
    end else if (op == lpm_rt_pkg::OP_DEL) begin
      status_next = exact_hit ? lpm_rt_pkg::ST_DELETED : lpm_rt_pkg::ST_NOT_FOUND;
    end else if (lpm_hit) begin
      matched_len_next = best.len;
      result_intf_next = best.intf;
      ttl_out_next = ttl;
      if (best.direct) begin
        status_next = lpm_rt_pkg::ST_DIRECT;
        next_hop_next = addr;
      end else begin
        status_next = lpm_rt_pkg::ST_GATEWAY;
        next_hop_next = best.gateway;
        if (op == lpm_rt_pkg::OP_FWD) begin
          if (ttl <= 8'd1) begin
            status_next = lpm_rt_pkg::ST_TTL_EXP;
            ttl_out_next = '0;
          end else begin
            ttl_out_next = ttl - 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op   <= operation;
            // Lookups keep the full destination; add and delete keep the masked prefix.
            addr <= (operation == lpm_rt_pkg::OP_FWD || operation == lpm_rt_pkg::OP_LOCAL) ?
                    address : (address & lpm_rt_pkg::len_mask(in_len));
            len  <= in_len;
            dir  <= direct_route;
            gw   <= in_gw;
            intf <= in_intf;
            ttl  <= ttl_in;
            cnt  <= '0;
            exact_hit <= 1'b0;
            free_hit  <= 1'b0;
            ident     <= 1'b0;
            lpm_hit   <= 1'b0;
            if (operation == lpm_rt_pkg::OP_FWD || operation == lpm_rt_pkg::OP_LOCAL ||
                operation == lpm_rt_pkg::OP_ADD || operation == lpm_rt_pkg::OP_DEL) begin
              state <= S_SCAN;
            end else if (operation == lpm_rt_pkg::OP_CLEAR) begin
              status <= lpm_rt_pkg::ST_CLEARED;
              next_hop <= '0;
              result_intf <= '0;
              ttl_out <= '0;
              matched_len <= '0;
              out_valid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (head_exact && !exact_hit) begin
            exact_hit <= 1'b1;
            exact_pos <= cnt;
            ident <= head.direct == dir && head.gateway == gw && head.intf == intf;
          end
          if (!head.valid && !free_hit) begin
            free_hit <= 1'b1;
            free_pos <= cnt;
          end
          // Strictly longer wins, so the lowest slot keeps ties.
          if (head_match && (!lpm_hit || head.len > best.len)) begin
            lpm_hit <= 1'b1;
            best <= head;
          end
          if (cnt == LAST) begin
            cnt <= '0;
            state <= (op == lpm_rt_pkg::OP_ADD || op == lpm_rt_pkg::OP_DEL) ? S_WRITE : S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_WRITE: begin
          if (cnt == LAST) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          status <= status_next;
          next_hop <= next_hop_next;
          result_intf <= result_intf_next;
          ttl_out <= ttl_out_next;
          matched_len <= matched_len_next;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, state != S_IDLE, !in_ready)
  `ASSERT_IMPL(a_write_only_pass2, cmd.write, state == S_WRITE)
  `ASSERT_NEXT(a_done_result, state == S_DONE, out_valid && state == S_IDLE)
  `ASSERT_IMPL(a_status_range, out_valid, status <= lpm_rt_pkg::ST_CLEARED)
endmodule

### verif/lpm_route_table_unit_tb.sv
// Testbench for the route table: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module lpm_route_table_unit_tb;
  localparam int ItemCount = 900;
  localparam int Slots = lpm_rt_pkg::TableSize;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [31:0] address = '0;
  logic [5:0]  prefix_len = '0;
  logic        direct_route = 1'b0;
  logic [31:0] gateway = '0;
  logic [3:0]  out_intf = '0;
  logic [7:0]  ttl_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  status;
  logic [31:0] next_hop;
  logic [3:0]  result_intf;
  logic [7:0]  ttl_out;
  logic [5:0]  matched_len;

  int error_count = 0;
  bit hold_off = 1'b0;

  lpm_route_table_unit dut (.*);

  always #6 clk = ~clk;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] next_hop;
    logic [3:0]  intf;
    logic [7:0]  ttl;
    logic [5:0]  mlen;
  } route_result_t;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  class route_scoreboard;
    bit          valid_q[Slots];
    logic [31:0] prefix_q[Slots];
    logic [5:0]  len_q[Slots];
    bit          direct_q[Slots];
    logic [31:0] gw_q[Slots];
    logic [3:0]  intf_q[Slots];
    route_result_t pending[$];

    function logic [31:0] mask_of(input logic [5:0] len);
      if (len == 0) return 32'h0;
      return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function int find_route(input logic [31:0] pfx, input logic [5:0] len);
      for (int i = 0; i < Slots; i++)
        if (valid_q[i] && prefix_q[i] == pfx && len_q[i] == len) return i;
      return -1;
    endfunction

    // Predict the result of one accepted request.
    function void note_request(input logic [2:0] op, input logic [31:0] addr,
                               input logic [5:0] len_in, input bit dir,
                               input logic [31:0] gw_in, input logic [3:0] intf_in,
                               input logic [7:0] ttl);
      route_result_t r;
      logic [5:0] len;
      logic [31:0] pfx, gw;
      logic [3:0] intf;
      int i, best;
      r = '0;
      len = (len_in > 32) ? 6'd32 : len_in;
      pfx = addr & mask_of(len);
      gw = dir ? 32'h0 : gw_in;
      intf = dir ? 4'h0 : 4'(32'(intf_in) % lpm_rt_pkg::IntfCount);
      case (op)
        lpm_rt_pkg::OP_ADD: begin
          i = find_route(pfx, len);
          if (i >= 0) begin
            if (direct_q[i] == dir && gw_q[i] == gw && intf_q[i] == intf) begin
              r.status = lpm_rt_pkg::ST_IDENT;
            end else begin
              direct_q[i] = dir; gw_q[i] = gw; intf_q[i] = intf;
              r.status = lpm_rt_pkg::ST_REPLACED;
            end
          end else begin
            i = 0;
            while (i < Slots && valid_q[i]) i++;
            if (i >= Slots) begin
              r.status = lpm_rt_pkg::ST_FULL;
            end else begin
              valid_q[i] = 1'b1; prefix_q[i] = pfx; len_q[i] = len;
              direct_q[i] = dir; gw_q[i] = gw; intf_q[i] = intf;
              r.status = lpm_rt_pkg::ST_ADDED;
            end
          end
        end
        lpm_rt_pkg::OP_DEL: begin
          i = find_route(pfx, len);
          if (i >= 0) begin
            valid_q[i] = 1'b0;
            r.status = lpm_rt_pkg::ST_DELETED;
          end else begin
            r.status = lpm_rt_pkg::ST_NOT_FOUND;
          end
        end
        lpm_rt_pkg::OP_FWD, lpm_rt_pkg::OP_LOCAL: begin
          best = -1;
          for (int k = 0; k < Slots; k++)
            if (valid_q[k] && (addr & mask_of(len_q[k])) == prefix_q[k] &&
                (best < 0 || len_q[k] > len_q[best])) best = k;
          if (best < 0) begin
            r.status = lpm_rt_pkg::ST_NO_ROUTE;
          end else begin
            r.mlen = len_q[best];
            r.intf = intf_q[best];
            r.ttl = ttl;
            if (direct_q[best]) begin
              r.status = lpm_rt_pkg::ST_DIRECT;
              r.next_hop = addr;
            end else begin
              r.status = lpm_rt_pkg::ST_GATEWAY;
              r.next_hop = gw_q[best];
              if (op == lpm_rt_pkg::OP_FWD) begin
                if (ttl <= 8'd1) begin
                  r.status = lpm_rt_pkg::ST_TTL_EXP;
                  r.ttl = '0;
                end else begin
                  r.ttl = ttl - 8'd1;
                end
              end
            end
          end
        end
        lpm_rt_pkg::OP_CLEAR: begin
          for (int k = 0; k < Slots; k++) valid_q[k] = 1'b0;
          r.status = lpm_rt_pkg::ST_CLEARED;
        end
        default: return;
      endcase
      pending.push_back(r);
    endfunction

    task check_result(input route_result_t got);
      route_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.status, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.next_hop !== want.next_hop)
        report_mismatch("next_hop", got.next_hop, want.next_hop);
      if (got.intf !== want.intf) report_mismatch("result_intf", got.intf, want.intf);
      if (got.ttl !== want.ttl) report_mismatch("ttl_out", got.ttl, want.ttl);
      if (got.mlen !== want.mlen) report_mismatch("matched_len", got.mlen, want.mlen);
    endtask
  endclass

  route_scoreboard routes = new();

  // Drive one request and hold it until the transfer; valid stays up into a gapless next item.
  task automatic send_request(input logic [2:0] op, input logic [31:0] addr,
                              input logic [5:0] len, input bit dir,
                              input logic [31:0] gw, input logic [3:0] intf,
                              input logic [7:0] ttl, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op; address <= addr; prefix_len <= len; direct_route <= dir;
    gateway <= gw; out_intf <= intf; ttl_in <= ttl; in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    routes.note_request(op, addr, len, dir, gw, intf, ttl);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (routes.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Pick an address, mostly from a small pool, so adds, deletes and lookups collide.
  function automatic logic [31:0] pool_addr();
    logic [31:0] base;
    base = {8'd10, 6'($urandom_range(0, 3)), 18'h0};
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return base;
      default: return base | ($urandom() & 32'h0003_FFFF);
    endcase
  endfunction

  function automatic logic [5:0] pool_len();
    case ($urandom_range(0, 5))
      0: return 6'($urandom_range(0, 63));
      1: return 6'd0;
      2: return 6'd32;
      default: return 6'($urandom_range(8, 16));
    endcase
  endfunction

  task automatic random_request(input int gap);
    int pick;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = lpm_rt_pkg::OP_ADD;
    else if (pick < 50) op = lpm_rt_pkg::OP_DEL;
    else if (pick < 75) op = lpm_rt_pkg::OP_FWD;
    else if (pick < 95) op = lpm_rt_pkg::OP_LOCAL;
    else if (pick < 97) op = lpm_rt_pkg::OP_CLEAR;
    else op = 3'($urandom_range(5, 7));
    send_request(op, pool_addr(), pool_len(), 1'($urandom()), $urandom(),
                 4'($urandom()), 8'($urandom()), gap);
  endtask

  // Receiver: a random wait before each result, plus a long hold-off when asked.
  initial begin
    int wait_cycles;
    @(negedge clk);
    forever begin
      wait_cycles = $urandom_range(0, 17);
      if (wait_cycles > 0 || rst || hold_off) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
        while (rst || hold_off) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      routes.check_result('{status, next_hop, result_intf, ttl_out, matched_len});
  end

  initial begin
    int gap;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: empty-table lookups, defaults, replace, identical, ttl cases, invalid opcodes, full table, clear
    send_request(lpm_rt_pkg::OP_FWD, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 4'h0, 8'd64, 0);
    send_request(lpm_rt_pkg::OP_DEL, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_ADD, 32'h1234_5678, 6'd0, 1'b0, 32'hC0A8_0001, 4'hF, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_ADD, 32'h0A01_0203, 6'd16, 1'b1, 32'hFFFF_FFFF, 4'h5, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_ADD, 32'h0A01_0203, 6'd16, 1'b1, 32'h1, 4'h9, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd63, 1'b0, 32'hFFFF_FFFF, 4'hA, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd32, 1'b0, 32'hFFFF_FFFF, 4'hA, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0001, 4'h3, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_FWD, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 4'h0, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_FWD, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 4'h0, 8'd1, 0);
    send_request(lpm_rt_pkg::OP_FWD, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 4'h0, 8'd255, 0);
    send_request(lpm_rt_pkg::OP_LOCAL, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 4'h0, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_FWD, 32'h0A01_FFFF, 6'd0, 1'b0, 32'h0, 4'h0, 8'd1, 0);
    send_request(lpm_rt_pkg::OP_LOCAL, 32'h0000_0000, 6'd0, 1'b0, 32'h0, 4'h0, 8'd7, 0);
    send_request(3'd5, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0, 8'd0, 0);
    send_request(3'd7, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'hF, 8'hFF, 0);
    send_request(lpm_rt_pkg::OP_DEL, 32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0, 4'h0, 8'd0, 0);
    for (int i = 0; i < 17; i++)
      send_request(lpm_rt_pkg::OP_ADD, {4'(i), 28'h0}, 6'd20, 1'b0, $urandom(), 4'(i),
                   8'd0, 0);
    send_request(lpm_rt_pkg::OP_CLEAR, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0, 8'd0, 0);
    send_request(lpm_rt_pkg::OP_FWD, 32'h0A01_0203, 6'd0, 1'b0, 32'h0, 4'h0, 8'd9, 0);
    // pause until every result is in
    wait_drained();
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) random_request(0);
    join
    for (int i = 0; i < ItemCount; i++) begin
      gap = ((i / 100) % 2 == 1) ? 0 : $urandom_range(0, 17);
      random_request(gap);
    end
    wait_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/lpm_rt_pkg.sv
rtl/lpm_rt_cell.sv
rtl/lpm_rt_chain.sv
rtl/lpm_route_table_unit.sv
verif/lpm_route_table_unit_tb.sv
